FILE: src/wsfd_pkg.sv
`default_nettype none

package wsfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 64;
    localparam int unsigned KEY_W  = 32;
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned IDX_W  = 2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [CNT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [CNT_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [CNT_W-1:0] KEY_BYTES   = 4'd4;

    typedef enum logic [4:0] {
        PH_FIRST   = 5'b00001,
        PH_SECOND  = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] data;
        logic              last;
    } beat_t;

endpackage

`default_nettype wire

FILE: src/wsfd_parser.sv
`default_nettype none

module wsfd_parser (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_take,
    input  wire logic [7:0]             in_byte,
    output wsfd_pkg::beat_t             res
);
    import wsfd_pkg::*;

    phase_t              phase_reg,  phase_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [LEN_W-1:0]    len_reg,    len_next;
    logic                mask_reg,   mask_next;
    logic [KEY_W-1:0]    key_reg,    key_next;
    logic [LEN_W-1:0]    rem_reg,    rem_next;
    logic [IDX_W-1:0]    idx_reg,    idx_next;

    logic [6:0]          len7;
    logic [CNT_W-1:0]    cnt_dec;
    logic [LEN_W-1:0]    len_shift;
    logic                hdr_done;
    logic [BYTE_W-1:0]   key_byte;
    logic                last;

    assign len7      = in_byte[6:0];
    assign cnt_dec   = cnt_reg - 4'd1;
    assign len_shift = {len_reg[LEN_W-BYTE_W-1:0], in_byte};
    assign last      = (rem_reg == {{(LEN_W-1){1'b0}}, 1'b1});

    always_comb begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        mask_next  = mask_reg;
        key_next   = key_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        hdr_done   = 1'b0;
        res.vld    = 1'b0;
        res.data   = in_byte;
        res.last   = 1'b0;

        case (phase_reg)
            PH_SECOND: begin
                mask_next = in_byte[7];
                key_next  = '0;
                if (len7 == LEN7_EXT16) begin
                    phase_next = PH_EXTLEN;
                    cnt_next   = EXT16_BYTES;
                    len_next   = '0;
                end else if (len7 == LEN7_EXT64) begin
                    phase_next = PH_EXTLEN;
                    cnt_next   = EXT64_BYTES;
                    len_next   = '0;
                end else begin
                    cnt_next = '0;
                    len_next = {{(LEN_W-7){1'b0}}, len7};
                    hdr_done = 1'b1;
                end
            end
            PH_EXTLEN: begin
                len_next = len_shift;
                cnt_next = cnt_dec;
                hdr_done = (cnt_dec == '0);
            end
            PH_KEY: begin
                key_next = {key_reg[KEY_W-BYTE_W-1:0], in_byte};
                cnt_next = cnt_dec;
                if (cnt_dec == '0) begin
                    if (len_reg == '0) begin
                        phase_next = PH_FIRST;
                    end else begin
                        phase_next = PH_PAYLOAD;
                        rem_next   = len_reg;
                        idx_next   = '0;
                    end
                end
            end
            PH_PAYLOAD: begin
                res.vld  = 1'b1;
                res.data = mask_reg ? (in_byte ^ key_byte) : in_byte;
                res.last = last;
                rem_next = rem_reg - 64'd1;
                idx_next = idx_reg + 2'd1;
                if (last) begin
                    phase_next = PH_FIRST;
                end
            end
            default: begin
                phase_next = PH_SECOND;
            end
        endcase

        if (hdr_done) begin
            if (mask_next) begin
                phase_next = PH_KEY;
                cnt_next   = KEY_BYTES;
                key_next   = '0;
            end else if (len_next == '0) begin
                phase_next = PH_FIRST;
            end else begin
                phase_next = PH_PAYLOAD;
                rem_next   = len_next;
                idx_next   = '0;
            end
        end

        if (!in_take) begin
            res.vld = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            cnt_reg   <= '0;
            mask_reg  <= 1'b0;
        end else if (in_take) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            len_reg <= len_next;
            key_reg <= key_next;
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/websocket_frame_decoder.sv
// A payload word appears on m_tdata in the cycle after it is accepted.
// Throughput: one word per cycle; header, length and key words yield no output.
// Input stalls only while the output register holds a word that is not taken.
// Reset (aresetn low, synchronous): parser waits for a frame's first header
// word and the output register is emptied.
`default_nettype none

module websocket_frame_decoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast
);
    import wsfd_pkg::*;

    logic              take;
    beat_t             res;
    logic              m_tvalid_reg;
    logic [BYTE_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    wsfd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (take),
        .in_byte (s_tdata),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (take) begin
            m_tvalid_reg <= res.vld;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.vld) begin
            m_tdata_reg <= res.data;
            m_tlast_reg <= res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire
